// ===== src/dbl_pkg.sv =====
// Shared constants and types for the debounce and long-press block.
`default_nettype none
package dbl_pkg;

    localparam int DBL_TIME_WIDTH = 32;   // default width of the internal time arithmetic
    localparam int DBL_TIME_IN_W  = 32;   // width of the time_ms field
    localparam int DBL_CFG_W      = 16;   // width of each configuration register
    localparam int DBL_CFG_ADDR_W = 8;

    typedef logic [2:0] event_t;

    localparam event_t EV_UP            = 3'd0;
    localparam event_t EV_JUST_DOWN     = 3'd1;
    localparam event_t EV_HELD_SHORT    = 3'd2;
    localparam event_t EV_LONG_FIRED    = 3'd3;
    localparam event_t EV_HELD_LONG     = 3'd4;
    localparam event_t EV_SHORT_CLICK   = 3'd5;
    localparam event_t EV_RELEASED_LONG = 3'd6;

    localparam logic [DBL_CFG_ADDR_W-1:0] REG_DEBOUNCE_MS   = 8'd0;
    localparam logic [DBL_CFG_ADDR_W-1:0] REG_LONG_PRESS_MS = 8'd1;

    localparam logic [DBL_CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd20;
    localparam logic [DBL_CFG_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

    // Debounce stage verdict for one item
    typedef struct packed {
        logic settle;   // window expired on this item, level accepted
        logic level;    // stable level after this item
    } deb_status_t;

endpackage
`default_nettype wire

// ===== src/dbl_debounce.sv =====
// Debounce stage: tracks the raw level and accepts it after a stable window.
`default_nettype none
module dbl_debounce
    import dbl_pkg::*;
#(
    parameter int TIME_WIDTH = DBL_TIME_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  level,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire logic [DBL_CFG_W-1:0]  debounce_ms,
    output deb_status_t                status
);

    localparam int CmpW = (TIME_WIDTH > DBL_CFG_W) ? TIME_WIDTH : DBL_CFG_W;

    logic                  candidate_reg, candidate_next;
    logic [TIME_WIDTH-1:0] change_time_reg, change_time_next;
    logic                  settling_reg, settling_next;
    logic                  stable_reg, stable_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  expired;

    assign elapsed = now - change_time_reg;   // wraps modulo 2^TIME_WIDTH
    assign expired = CmpW'(elapsed) > CmpW'(debounce_ms);

    always_comb
    begin
        candidate_next   = candidate_reg;
        change_time_next = change_time_reg;
        settling_next    = settling_reg;
        stable_next      = stable_reg;
        status.settle    = 1'b0;
        if (level != candidate_reg)
        begin
            candidate_next   = level;
            change_time_next = now;
            settling_next    = 1'b1;
        end
        else if (settling_reg && expired)
        begin
            settling_next = 1'b0;
            stable_next   = candidate_reg;
            status.settle = 1'b1;
        end
        status.level = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg   <= 1'b0;
            change_time_reg <= '0;
            settling_reg    <= 1'b0;
            stable_reg      <= 1'b0;
        end
        else if (en)
        begin
            candidate_reg   <= candidate_next;
            change_time_reg <= change_time_next;
            settling_reg    <= settling_next;
            stable_reg      <= stable_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/dbl_press.sv =====
// Press stage: times accepted presses and picks the event code.
`default_nettype none
module dbl_press
    import dbl_pkg::*;
#(
    parameter int TIME_WIDTH = DBL_TIME_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire deb_status_t           status,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire logic [DBL_CFG_W-1:0]  long_press_ms,
    output event_t                     evt
);

    localparam int CmpW = (TIME_WIDTH > DBL_CFG_W) ? TIME_WIDTH : DBL_CFG_W;

    logic                  timing_reg, timing_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [TIME_WIDTH-1:0] held;
    logic                  is_long;

    assign held    = now - start_reg;
    assign is_long = CmpW'(held) > CmpW'(long_press_ms);

    always_comb
    begin
        timing_next = timing_reg;
        start_next  = start_reg;
        if (status.settle && status.level)
        begin
            timing_next = 1'b1;
            start_next  = now;
            evt         = EV_JUST_DOWN;
        end
        else if (status.settle)
        begin
            // timing flag survives a short click on purpose
            evt = timing_reg ? EV_SHORT_CLICK : EV_RELEASED_LONG;
        end
        else if (status.level)
        begin
            if (!timing_reg)
            begin
                evt = EV_HELD_LONG;
            end
            else if (is_long)
            begin
                timing_next = 1'b0;
                evt         = EV_LONG_FIRED;
            end
            else
            begin
                evt = EV_HELD_SHORT;
            end
        end
        else
        begin
            evt = EV_UP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (en)
        begin
            timing_reg <= timing_next;
            start_reg  <= start_next;
        end
    end

`ifndef SYNTH
    a_down_arms: assert property (@(posedge clk) disable iff (!rst_n)
        en && evt == EV_JUST_DOWN |=> timing_reg && start_reg == $past(now))
        else $error("press timer not armed after press");

    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        en && evt == EV_LONG_FIRED |=> !timing_reg)
        else $error("long-press timer still running after firing");

    a_rel_long: assert property (@(posedge clk) disable iff (!rst_n)
        en && evt == EV_RELEASED_LONG |-> !timing_reg)
        else $error("long release reported while press still timed");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(timing_reg) && $stable(start_reg))
        else $error("press state moved without an item");
`endif

endmodule
`default_nettype wire

// ===== src/debounce_with_long_press.sv =====
// Top level: button debouncer with long-press detection.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+----------------------------------------
//  s_axis   | in  | s_tvalid / s_tready   | s_tdata[0] raw_level, [32:1] time_ms
//  m_axis   | out | m_tvalid / m_tready   | m_tdata[2:0] event_res
//  cfg      | in  | cfg_valid / cfg_ready | cfg_addr index, cfg_data[15:0] value
//
// One item per cycle sustained while m_tready is high; the result passes
// through the input register, then the result register. State moves as an
// item leaves the input register. A stalled output holds the result and the
// input register keeps one more item before s_tready drops. Reset clears the
// debounce and press state and loads the register defaults; no clearing pass.
`default_nettype none
module debounce_with_long_press
    import dbl_pkg::*;
#(
    parameter int TIME_WIDTH = DBL_TIME_WIDTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [39:0]               s_tdata,   // [0] raw_level, [32:1] time_ms, rest 0
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,   // [2:0] event_res, rest 0
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [DBL_CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DBL_CFG_W-1:0]      cfg_data
);

    logic                     in_vld_reg;
    logic                     in_level_reg;
    logic [DBL_TIME_IN_W-1:0] in_time_reg;
    logic                     out_vld_reg;
    event_t                   out_evt_reg;
    logic [DBL_CFG_W-1:0]     debounce_ms_reg;
    logic [DBL_CFG_W-1:0]     long_press_ms_reg;
    logic                     advance;
    logic [TIME_WIDTH-1:0]    now;
    deb_status_t              status;
    event_t                   evt;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {5'd0, out_evt_reg};
    assign now       = TIME_WIDTH'(in_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_MS_RST;
            long_press_ms_reg <= LONG_PRESS_MS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                REG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[32:1];
        end
        if (advance)
        begin
            out_evt_reg <= evt;
        end
    end

    dbl_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .level       (in_level_reg),
        .now         (now),
        .debounce_ms (debounce_ms_reg),
        .status      (status)
    );

    dbl_press #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_press (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .status        (status),
        .now           (now),
        .long_press_ms (long_press_ms_reg),
        .evt           (evt)
    );

`ifndef SYNTH
    a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_evt_reg != 3'd7)
        else $error("undefined event code");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled without back pressure");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg && out_evt_reg == $past(evt))
        else $error("result register missed an item");
`endif

endmodule
`default_nettype wire
